// ===== design/tcw_pkg.sv =====
// Shared types and constants of the text console writer.
// Used by tcw_ctrl, tcw_datapath and text_console_writer_top; depends on nothing.
`default_nettype none

package tcw_pkg;

  // Default sizes
  localparam int unsigned CELL_DEPTH_DEF = 8192;
  localparam int unsigned TAB_STOP_DEF   = 8;

  // Internal widths: index/counter, column, row
  localparam int IW = 15;
  localparam int CW = 13;
  localparam int RW = 6;

  // Screen geometry for the two modes
  localparam logic [6:0] W_HI = 7'd90;
  localparam logic [5:0] H_HI = 6'd60;
  localparam logic [6:0] W_LO = 7'd80;
  localparam logic [5:0] H_LO = 6'd25;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Configuration register indexes
  localparam logic [2:0] CFG_HI_RES  = 3'd0;
  localparam logic [2:0] CFG_ESCAPE  = 3'd1;
  localparam logic [2:0] CFG_VERIFY1 = 3'd2;
  localparam logic [2:0] CFG_VERIFY2 = 3'd3;
  localparam logic [2:0] CFG_CLEAR   = 3'd4;
  localparam logic [2:0] CFG_MOVE    = 3'd5;

  // Configuration reset values
  localparam logic       RST_HI_RES  = 1'b1;
  localparam logic [7:0] RST_ESCAPE  = 8'd255;
  localparam logic [7:0] RST_VERIFY1 = 8'd170;
  localparam logic [7:0] RST_VERIFY2 = 8'd85;
  localparam logic [7:0] RST_CLEAR   = 8'd0;
  localparam logic [7:0] RST_MOVE    = 8'd1;
  localparam logic [7:0] RST_COLOR   = 8'd7;

  // Datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_INIT_WR,
    OP_LOAD,
    OP_READ,
    OP_RD_LATCH,
    OP_SEL_HELD,
    OP_SEL_B,
    OP_HOLD,
    OP_GATHER,
    OP_COLOR,
    OP_MOVE_MUL,
    OP_MOVE,
    OP_NL,
    OP_CR,
    OP_DEC_COL,
    OP_BS_POST,
    OP_TAB1,
    OP_TAB2,
    OP_TAB3,
    OP_IDX,
    OP_WR_CHAR,
    OP_FIX,
    OP_CLR_SWEEP,
    OP_SCR_START,
    OP_SCR_RD,
    OP_SCR_WR,
    OP_SCR_FILL,
    OP_SCR_END
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] byte_k;
  } dp_cmd_t;

  typedef struct packed {
    logic is_read;
    logic is_first;
    logic b_eq_vf;
    logic b_eq_vs;
    logic b_eq_esc;
    logic b_eq_clr;
    logic b_eq_mov;
    logic c_zero;
    logic c_nl;
    logic c_cr;
    logic c_bs;
    logic c_tab;
    logic col_nz;
    logic row_ge_h;
    logic init_last;
    logic clr_last;
    logic scr_end;
    logic scr_copy;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/tcw_datapath.sv =====
// Datapath of the text console writer: config registers, cursor, cell memories,
// tab/move arithmetic and scroll/clear address counter. Depends on tcw_pkg.
`default_nettype none

module tcw_datapath #(
  parameter int unsigned CELL_DEPTH = tcw_pkg::CELL_DEPTH_DEF,
  parameter int unsigned TAB_STOP   = tcw_pkg::TAB_STOP_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [2:0]             cfg_idx_i,
  input  wire logic [7:0]             cfg_data_i,
  input  wire logic                   req_type_i,
  input  wire logic [7:0]             data_byte_i,
  input  wire logic                   first_of_write_i,
  input  wire logic [12:0]            cell_index_i,
  input  wire tcw_pkg::dp_cmd_t       cmd_i,
  output tcw_pkg::dp_stat_t           stat_o,
  output logic [tcw_pkg::CW-1:0]      cursor_col_o,
  output logic [tcw_pkg::RW-1:0]      cursor_row_o,
  output logic [7:0]                  read_char_o,
  output logic [7:0]                  read_attr_o,
  output logic                        status_o
);
  import tcw_pkg::*;

  localparam int unsigned AW = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;
  localparam logic [IW-1:0] DEPTH_V    = IW'(CELL_DEPTH);
  localparam logic [IW-1:0] DEPTH_LAST = IW'(CELL_DEPTH - 1);
  // Reciprocal of the tab stop, scaled so the quotient is off by at most one
  localparam int unsigned   TAB_SH = 17;
  localparam logic [17:0]   TAB_M  = 18'((2 ** TAB_SH) / TAB_STOP);
  localparam logic [13:0]   TAB_V  = 14'(TAB_STOP);
  localparam logic [13:0]   TAB_V2 = 14'(2 * TAB_STOP);

  logic       hi_res_q;
  logic [7:0] esc_q, vf_q, vs_q, clrc_q, movc_q;

  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [7:0]    color_q;
  logic [IW-1:0] i_q, idx_q;
  logic [7:0]    b_q, c_q, held_q;
  logic          first_q, rtype_q;
  logic [12:0]   cidx_q;
  logic [31:0]   gather_q;
  logic [30:0]   tprod_q;
  logic [13:0]   tqt_q;
  logic [22:0]   mprod_q;
  logic          rok_q;
  logic [7:0]    rchar_q, rattr_q;
  logic          status_q;

  logic [7:0] char_mem [CELL_DEPTH];
  logic [7:0] attr_mem [CELL_DEPTH];
  logic [7:0] ch_rd_q, at_rd_q;

  logic [6:0]    w;
  logic [5:0]    h;
  logic [12:0]   n;
  logic [IW-1:0] n_ext, i_plus_w, cidx_ext;
  logic [CW-1:0] tq;
  logic [13:0]   tdiff;
  logic [23:0]   msum;
  logic          ch_we, at_we;
  logic [AW-1:0] wa, ra;
  logic [7:0]    ch_wd, at_wd;

  // Screen geometry
  assign w        = hi_res_q ? W_HI : W_LO;
  assign h        = hi_res_q ? H_HI : H_LO;
  assign n        = 13'(w) * 13'(h);
  assign n_ext    = IW'(n);
  assign i_plus_w = i_q + IW'(w);
  assign cidx_ext = IW'(cidx_q);
  assign tq       = tprod_q[TAB_SH +: CW];
  assign tdiff    = 14'(col_q) - tqt_q;
  assign msum     = 24'(gather_q[15:0]) + 24'(mprod_q);

  // Status toward the controller
  always_comb begin
    stat_o.is_read   = rtype_q;
    stat_o.is_first  = first_q;
    stat_o.b_eq_vf   = (b_q == vf_q);
    stat_o.b_eq_vs   = (b_q == vs_q);
    stat_o.b_eq_esc  = (b_q == esc_q);
    stat_o.b_eq_clr  = (b_q == clrc_q);
    stat_o.b_eq_mov  = (b_q == movc_q);
    stat_o.c_zero    = (c_q == CH_NUL);
    stat_o.c_nl      = (c_q == CH_NL);
    stat_o.c_cr      = (c_q == CH_CR);
    stat_o.c_bs      = (c_q == CH_BS);
    stat_o.c_tab     = (c_q == CH_TAB);
    stat_o.col_nz    = (col_q != '0);
    stat_o.row_ge_h  = (row_q >= h);
    stat_o.init_last = (i_q == DEPTH_LAST);
    stat_o.clr_last  = (i_q == n_ext - IW'(1));
    stat_o.scr_end   = (i_q >= n_ext) || (i_q >= DEPTH_V);
    stat_o.scr_copy  = (i_q < n_ext - IW'(w));
  end

  // Memory port control
  always_comb begin
    ch_we = 1'b0;
    at_we = 1'b0;
    wa    = i_q[AW-1:0];
    ra    = i_plus_w[AW-1:0];
    ch_wd = CH_SPACE;
    at_wd = color_q;
    case (cmd_i.op)
      OP_INIT_WR: begin
        ch_we = 1'b1;
        at_we = 1'b1;
        ch_wd = '0;
        at_wd = '0;
      end
      OP_WR_CHAR: begin
        ch_we = (idx_q < DEPTH_V);
        wa    = idx_q[AW-1:0];
        ch_wd = c_q;
      end
      OP_CLR_SWEEP: ch_we = (i_q < DEPTH_V);
      OP_SCR_WR: begin
        ch_we = 1'b1;
        at_we = 1'b1;
        ch_wd = rok_q ? ch_rd_q : '0;
        at_wd = rok_q ? at_rd_q : '0;
      end
      OP_SCR_FILL: begin
        ch_we = 1'b1;
        at_we = 1'b1;
      end
      OP_READ: ra = cidx_ext[AW-1:0];
      default: ;
    endcase
  end

  // Cell memories: char byte and attribute byte, one write and one read port
  always_ff @(posedge clk_i) begin
    if (ch_we) char_mem[wa] <= ch_wd;
    if (at_we) attr_mem[wa] <= at_wd;
    ch_rd_q <= char_mem[ra];
    at_rd_q <= attr_mem[ra];
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_res_q <= RST_HI_RES;
      esc_q    <= RST_ESCAPE;
      vf_q     <= RST_VERIFY1;
      vs_q     <= RST_VERIFY2;
      clrc_q   <= RST_CLEAR;
      movc_q   <= RST_MOVE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HI_RES:  hi_res_q <= cfg_data_i[0];
        CFG_ESCAPE:  esc_q    <= cfg_data_i;
        CFG_VERIFY1: vf_q     <= cfg_data_i;
        CFG_VERIFY2: vs_q     <= cfg_data_i;
        CFG_CLEAR:   clrc_q   <= cfg_data_i;
        CFG_MOVE:    movc_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Cursor, color, counter and working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      color_q  <= RST_COLOR;
      i_q      <= '0;
      idx_q    <= '0;
      b_q      <= '0;
      c_q      <= '0;
      held_q   <= '0;
      first_q  <= 1'b0;
      rtype_q  <= 1'b0;
      cidx_q   <= '0;
      gather_q <= '0;
      tprod_q  <= '0;
      tqt_q    <= '0;
      mprod_q  <= '0;
      rok_q    <= 1'b0;
      rchar_q  <= '0;
      rattr_q  <= '0;
      status_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        OP_INIT_WR: i_q <= i_q + IW'(1);
        OP_LOAD: begin
          b_q      <= data_byte_i;
          first_q  <= first_of_write_i;
          rtype_q  <= req_type_i;
          cidx_q   <= cell_index_i;
          rchar_q  <= '0;
          rattr_q  <= '0;
          status_q <= 1'b0;
        end
        OP_READ: rok_q <= (cidx_ext < DEPTH_V);
        OP_RD_LATCH: begin
          rchar_q <= rok_q ? ch_rd_q : '0;
          rattr_q <= rok_q ? at_rd_q : '0;
        end
        OP_SEL_HELD: c_q <= held_q;
        OP_SEL_B:    c_q <= b_q;
        OP_HOLD:     held_q <= b_q;
        OP_GATHER: begin
          if (cmd_i.byte_k == 2'd0) gather_q <= {24'd0, b_q};
          else gather_q[8*cmd_i.byte_k +: 8] <= b_q;
        end
        OP_COLOR: begin
          color_q <= b_q;
          col_q   <= '0;
          row_q   <= '0;
          i_q     <= '0;
        end
        OP_MOVE_MUL: mprod_q <= 23'(gather_q[31:16]) * 23'(w);
        OP_MOVE: begin
          if (msum < 24'(n)) begin
            col_q <= CW'(gather_q[15:0]);
            row_q <= RW'(gather_q[31:16]);
          end else begin
            status_q <= 1'b1;
          end
        end
        OP_NL: begin
          row_q <= row_q + RW'(1);
          col_q <= '0;
        end
        OP_CR: col_q <= '0;
        OP_DEC_COL: begin
          col_q <= col_q - CW'(1);
          c_q   <= CH_SPACE;
        end
        OP_BS_POST: if (col_q != '0) col_q <= col_q - CW'(1);
        OP_TAB1: tprod_q <= 31'(col_q) * 31'(TAB_M);
        OP_TAB2: tqt_q <= 14'(tq) * TAB_V;
        OP_TAB3: col_q <= (tdiff >= TAB_V) ? CW'(tqt_q + TAB_V2) : CW'(tqt_q + TAB_V);
        OP_IDX: idx_q <= IW'(col_q) + IW'(row_q) * IW'(w);
        OP_WR_CHAR: col_q <= col_q + CW'(1);
        OP_FIX: begin
          if (col_q >= CW'(w)) begin
            col_q <= '0;
            row_q <= row_q + RW'(1);
          end
        end
        OP_CLR_SWEEP: i_q <= i_q + IW'(1);
        OP_SCR_START: i_q <= '0;
        OP_SCR_RD:    rok_q <= (i_plus_w < DEPTH_V);
        OP_SCR_WR:    i_q <= i_q + IW'(1);
        OP_SCR_FILL:  i_q <= i_q + IW'(1);
        OP_SCR_END: begin
          col_q <= '0;
          row_q <= RW'(h - 6'd1);
        end
        default: ;
      endcase
    end
  end

  assign cursor_col_o = col_q;
  assign cursor_row_o = row_q;
  assign read_char_o  = rchar_q;
  assign read_attr_o  = rattr_q;
  assign status_o     = status_q;

endmodule

`default_nettype wire

// ===== design/tcw_ctrl.sv =====
// Controller of the text console writer: byte parser, print/scroll/clear sequencer
// and handshake. Drives tcw_datapath through dp_cmd_t; depends on tcw_pkg.
`default_nettype none

module tcw_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  output logic                    done_o,
  input  wire tcw_pkg::dp_stat_t  stat_i,
  output tcw_pkg::dp_cmd_t        cmd_o
);
  import tcw_pkg::*;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DISP, S_RD, S_TAKE, S_MV1, S_MV2, S_PR, S_TAB2, S_TAB3,
    S_WR, S_FIX, S_CHK, S_PRET, S_CLR, S_SCRI, S_SCR, S_SCRW
  } state_e;

  typedef enum logic [2:0] {PH_PLAIN, PH_HELD, PH_CMD, PH_COLOR, PH_MOVE} phase_e;

  typedef enum logic [1:0] {AP_DONE, AP_TAKE, AP_HOLD} after_e;

  state_e     state_q, state_d;
  phase_e     phase_q, phase_d;
  after_e     after_q, after_d;
  logic [1:0] mvk_q, mvk_d;
  logic       esc_q, esc_d, bs_q, bs_d, clr_q, clr_d, done_q, done_d;

  // Next state, parser state and datapath command
  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    after_d    = after_q;
    mvk_d      = mvk_q;
    esc_d      = esc_q;
    bs_d       = bs_q;
    clr_d      = clr_q;
    done_d     = 1'b0;
    cmd_o.op     = OP_NONE;
    cmd_o.byte_k = mvk_q;
    unique case (state_q)
      S_INIT: begin
        cmd_o.op = OP_INIT_WR;
        if (stat_i.init_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        if (stat_i.is_read) begin
          cmd_o.op = OP_READ;
          state_d  = S_RD;
        end else if (stat_i.is_first) begin
          // New write call: drop escapes, flush a held byte
          esc_d   = 1'b0;
          phase_d = PH_PLAIN;
          if (phase_q == PH_HELD) begin
            cmd_o.op = OP_SEL_HELD;
            after_d  = stat_i.b_eq_vf ? AP_HOLD : AP_TAKE;
            state_d  = S_PR;
          end else if (stat_i.b_eq_vf) begin
            cmd_o.op = OP_HOLD;
            phase_d  = PH_HELD;
            state_d  = S_IDLE;
            done_d   = 1'b1;
          end else begin
            state_d = S_TAKE;
          end
        end else if (phase_q == PH_HELD) begin
          phase_d = PH_PLAIN;
          if (stat_i.b_eq_vs) begin
            esc_d   = 1'b1;
            state_d = S_IDLE;
            done_d  = 1'b1;
          end else begin
            cmd_o.op = OP_SEL_HELD;
            after_d  = AP_TAKE;
            state_d  = S_PR;
          end
        end else begin
          state_d = S_TAKE;
        end
      end
      S_RD: begin
        cmd_o.op = OP_RD_LATCH;
        state_d  = S_IDLE;
        done_d   = 1'b1;
      end
      S_TAKE: begin
        case (phase_q)
          PH_PLAIN: begin
            if (esc_q && stat_i.b_eq_esc) begin
              phase_d = PH_CMD;
              state_d = S_IDLE;
              done_d  = 1'b1;
            end else begin
              cmd_o.op = OP_SEL_B;
              after_d  = AP_DONE;
              state_d  = S_PR;
            end
          end
          PH_CMD: begin
            phase_d = PH_PLAIN;
            if (stat_i.b_eq_esc) begin
              cmd_o.op = OP_SEL_B;
              after_d  = AP_DONE;
              state_d  = S_PR;
            end else begin
              if (stat_i.b_eq_clr) phase_d = PH_COLOR;
              else if (stat_i.b_eq_mov) begin
                phase_d = PH_MOVE;
                mvk_d   = 2'd0;
              end
              state_d = S_IDLE;
              done_d  = 1'b1;
            end
          end
          PH_COLOR: begin
            cmd_o.op = OP_COLOR;
            phase_d  = PH_PLAIN;
            state_d  = S_CLR;
          end
          PH_MOVE: begin
            cmd_o.op = OP_GATHER;
            if (mvk_q == 2'd3) begin
              phase_d = PH_PLAIN;
              state_d = S_MV1;
            end else begin
              mvk_d   = mvk_q + 2'd1;
              state_d = S_IDLE;
              done_d  = 1'b1;
            end
          end
          default: begin
            phase_d = PH_PLAIN;
            state_d = S_IDLE;
            done_d  = 1'b1;
          end
        endcase
      end
      S_MV1: begin
        cmd_o.op = OP_MOVE_MUL;
        state_d  = S_MV2;
      end
      S_MV2: begin
        cmd_o.op = OP_MOVE;
        state_d  = S_IDLE;
        done_d   = 1'b1;
      end
      // Print one character: classify and update cursor
      S_PR: begin
        if (stat_i.c_zero) begin
          state_d = S_PRET;
        end else if (stat_i.c_nl) begin
          cmd_o.op = OP_NL;
          state_d  = S_FIX;
        end else if (stat_i.c_cr) begin
          cmd_o.op = OP_CR;
          state_d  = S_FIX;
        end else if (stat_i.c_bs && stat_i.col_nz) begin
          cmd_o.op = OP_DEC_COL;
          bs_d     = 1'b1;
          state_d  = S_PR;
        end else if (stat_i.c_tab) begin
          cmd_o.op = OP_TAB1;
          state_d  = S_TAB2;
        end else begin
          cmd_o.op = OP_IDX;
          state_d  = S_WR;
        end
      end
      S_TAB2: begin
        cmd_o.op = OP_TAB2;
        state_d  = S_TAB3;
      end
      S_TAB3: begin
        cmd_o.op = OP_TAB3;
        state_d  = S_FIX;
      end
      S_WR: begin
        cmd_o.op = OP_WR_CHAR;
        state_d  = S_FIX;
      end
      S_FIX: begin
        cmd_o.op = OP_FIX;
        state_d  = S_CHK;
      end
      S_CHK: begin
        if (stat_i.row_ge_h) begin
          cmd_o.op = OP_SCR_START;
          state_d  = S_SCR;
        end else begin
          state_d = S_PRET;
        end
      end
      // Return from a print: finish backspace, then resume the parser
      S_PRET: begin
        if (bs_q) begin
          cmd_o.op = OP_BS_POST;
          bs_d     = 1'b0;
          state_d  = S_FIX;
        end else begin
          case (after_q)
            AP_TAKE: state_d = S_TAKE;
            AP_HOLD: begin
              cmd_o.op = OP_HOLD;
              phase_d  = PH_HELD;
              state_d  = S_IDLE;
              done_d   = 1'b1;
            end
            default: begin
              state_d = S_IDLE;
              done_d  = 1'b1;
            end
          endcase
        end
      end
      // Clear: fill the char of every screen cell with a space, then one scroll
      S_CLR: begin
        cmd_o.op = OP_CLR_SWEEP;
        if (stat_i.clr_last) begin
          clr_d   = 1'b1;
          state_d = S_SCRI;
        end
      end
      S_SCRI: begin
        cmd_o.op = OP_SCR_START;
        state_d  = S_SCR;
      end
      // Scroll: copy one row up, a read then a write per cell, then blank the last row
      S_SCR: begin
        if (stat_i.scr_end) begin
          cmd_o.op = OP_SCR_END;
          if (clr_q) begin
            clr_d   = 1'b0;
            state_d = S_IDLE;
            done_d  = 1'b1;
          end else begin
            state_d = S_PRET;
          end
        end else if (stat_i.scr_copy) begin
          cmd_o.op = OP_SCR_RD;
          state_d  = S_SCRW;
        end else begin
          cmd_o.op = OP_SCR_FILL;
        end
      end
      S_SCRW: begin
        cmd_o.op = OP_SCR_WR;
        state_d  = S_SCR;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      phase_q <= PH_PLAIN;
      after_q <= AP_DONE;
      mvk_q   <= 2'd0;
      esc_q   <= 1'b0;
      bs_q    <= 1'b0;
      clr_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      after_q <= after_d;
      mvk_q   <= mvk_d;
      esc_q   <= esc_d;
      bs_q    <= bs_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== design/text_console_writer_top.sv =====
// Top level of the text console writer: ties tcw_ctrl to tcw_datapath.
// Depends on tcw_pkg, tcw_ctrl and tcw_datapath.
//
// Usage: raise start for one cycle while busy is low to hand in a transaction:
// a read of one cell (req_type_i = 1, cell_index_i) or one byte of a write call
// (data_byte_i, first_of_write_i marks the first byte of a call). Exactly one
// result follows, shown for one cycle with done_o high: cursor position, read
// cell bytes (zero for writes) and move status. The receiver cannot stall.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i while idle.
// The user must keep to this; the block does not enforce it. A first byte that
// flushes a held byte first prints that held byte. A print that overflows the
// screen triggers a scroll of every row, and a clear sweeps the char of every
// screen cell before that scroll. The clear sweep, like the one after reset,
// writes one cell a cycle.
// After reset the block clears the cell memory with busy high; cursor goes to
// the origin and text color to 7.
`default_nettype none

module text_console_writer_top #(
  parameter int unsigned CELL_DEPTH = tcw_pkg::CELL_DEPTH_DEF,
  parameter int unsigned TAB_STOP   = tcw_pkg::TAB_STOP_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic                   cfg_we_i,
  input  wire logic [2:0]             cfg_idx_i,
  input  wire logic [7:0]             cfg_data_i,
  input  wire logic                   req_type_i,
  input  wire logic [7:0]             data_byte_i,
  input  wire logic                   first_of_write_i,
  input  wire logic [12:0]            cell_index_i,
  output logic                        done_o,
  output logic [tcw_pkg::CW-1:0]      cursor_col_o,
  output logic [tcw_pkg::RW-1:0]      cursor_row_o,
  output logic [7:0]                  read_char_o,
  output logic [7:0]                  read_attr_o,
  output logic                        status_o
);
  import tcw_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tcw_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  tcw_datapath #(
    .CELL_DEPTH (CELL_DEPTH),
    .TAB_STOP   (TAB_STOP)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .req_type_i       (req_type_i),
    .data_byte_i      (data_byte_i),
    .first_of_write_i (first_of_write_i),
    .cell_index_i     (cell_index_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cursor_col_o     (cursor_col_o),
    .cursor_row_o     (cursor_row_o),
    .read_char_o      (read_char_o),
    .read_attr_o      (read_attr_o),
    .status_o         (status_o)
  );

endmodule

`default_nettype wire
